// File: src/pfx_pkg.sv
// shared types and constants for the packet framer with xor checksum
// no dependencies
`default_nettype none

package pfx_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_FIELD_W = 16;

    localparam logic [BYTE_W-1:0] FRAME_HEADER  = 8'h7E;
    localparam logic [BYTE_W-1:0] FRAME_TRAILER = 8'hE7;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one command per accepted input beat: which frame pieces to send
    typedef struct packed {
        logic                   has_header;
        logic                   has_payload;
        logic                   has_closing;
        logic [LEN_FIELD_W-1:0] length;
        logic [BYTE_W-1:0]      payload;
        logic [BYTE_W-1:0]      checksum;
    } cmd_t;

    // byte position within one command's output run
    typedef enum logic [5:0] {
        ST_HDR     = 6'b000001,
        ST_LEN_LO  = 6'b000010,
        ST_LEN_HI  = 6'b000100,
        ST_PAYLOAD = 6'b001000,
        ST_TRAILER = 6'b010000,
        ST_CHECK   = 6'b100000
    } step_t;

endpackage

`default_nettype wire

// File: src/packet_framer_xor_checksum_unit.sv
// top level of the length-prefixed packet framer with xor checksum
// depends on pfx_pkg, pfx_front, pfx_queue, pfx_back
`default_nettype none

// Byte framer: each input beat carries one payload byte; the first beat of a
// packet also carries its length. The output is one frame byte per beat:
// header 0x7E, length low byte, length high byte, the payload bytes, trailer
// 0xE7 and finally the xor of all payload bytes (frame_end marks that byte).
// run_last marks the final output beat caused by each input beat. A packet of
// length zero takes one input beat (its byte is ignored) and gives header,
// two zero length bytes, trailer and checksum zero. Lengths are cut to their
// low LENGTH_BITS bits, both for counting and in the header. The front end
// updates the packet count and running xor as beats arrive and drops one
// command per beat into a four-entry queue; the back end turns each command
// into its bytes through a registered output stage. While m_ready holds, the
// output side sends one byte per cycle, so inside a packet the block sustains
// one input beat per cycle; a packet's first beat gives four output bytes (six
// for a one-byte packet) and its last beat three, and the queue soaks up those
// bursts. A result's bytes pass the queue, command and output registers.
module packet_framer_xor_checksum_unit #(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input beats
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_payload_byte,
    input  wire logic [15:0] s_packet_length,
    // frame bytes
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_run_last,
    output logic             m_frame_end
);

    pfx_pkg::cmd_t front_cmd;
    pfx_pkg::cmd_t head_cmd;
    logic          take;
    logic          q_not_empty;
    logic          q_not_full;
    logic          q_pop;

    // a beat is taken whenever the queue has room for its command
    assign s_ready = q_not_full;
    assign take    = s_valid && q_not_full;

    // packet tracking and command build
    pfx_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .take          (take),
        .payload_byte  (s_payload_byte),
        .packet_length (s_packet_length),
        .cmd           (front_cmd)
    );

    // decoupling queue
    pfx_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (take),
        .push_cmd  (front_cmd),
        .pop       (q_pop),
        .head_cmd  (head_cmd),
        .not_empty (q_not_empty),
        .not_full  (q_not_full)
    );

    // byte sequencer and output register
    pfx_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_cmd    (head_cmd),
        .head_valid  (q_not_empty),
        .pop         (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_run_last  (m_run_last),
        .m_frame_end (m_frame_end)
    );

endmodule

`default_nettype wire

// File: src/pfx_front.sv
// front end: takes input beats, tracks packet state, builds one command per beat
// depends on pfx_pkg
`default_nettype none

module pfx_front #(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                take,
    input  wire logic [pfx_pkg::BYTE_W-1:0]          payload_byte,
    input  wire logic [pfx_pkg::LEN_FIELD_W-1:0]     packet_length,
    output pfx_pkg::cmd_t                            cmd
);

    logic                   in_packet_reg, in_packet_next;
    logic [LENGTH_BITS-1:0] remaining_reg, remaining_next;
    logic [pfx_pkg::BYTE_W-1:0] xor_reg, xor_next;
    logic [LENGTH_BITS-1:0] len_trunc;
    logic [LENGTH_BITS-1:0] count_dec;

    assign len_trunc = packet_length[LENGTH_BITS-1:0];

    always_comb begin
        count_dec      = '0;
        in_packet_next = in_packet_reg;
        remaining_next = remaining_reg;
        xor_next       = xor_reg;
        cmd            = '0;
        cmd.payload    = payload_byte;
        if (!in_packet_reg) begin
            cmd.has_header = 1'b1;
            cmd.length     = pfx_pkg::LEN_FIELD_W'(len_trunc);
            if (len_trunc == '0) begin
                // empty packet: header, length, trailer, zero checksum
                cmd.has_closing = 1'b1;
                xor_next        = '0;
                remaining_next  = '0;
            end else begin
                count_dec       = len_trunc - LENGTH_BITS'(1);
                cmd.has_payload = 1'b1;
                cmd.has_closing = (count_dec == '0);
                cmd.checksum    = payload_byte;
                xor_next        = payload_byte;
                remaining_next  = count_dec;
                in_packet_next  = (count_dec != '0);
            end
        end else begin
            count_dec       = remaining_reg - LENGTH_BITS'(1);
            xor_next        = xor_reg ^ payload_byte;
            cmd.has_payload = 1'b1;
            cmd.has_closing = (count_dec == '0);
            cmd.checksum    = xor_next;
            remaining_next  = count_dec;
            in_packet_next  = (count_dec != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_packet_reg <= 1'b0;
            remaining_reg <= '0;
            xor_reg       <= '0;
        end else if (take) begin
            in_packet_reg <= in_packet_next;
            remaining_reg <= remaining_next;
            xor_reg       <= xor_next;
        end
    end

endmodule

`default_nettype wire

// File: src/pfx_queue.sv
// small command fifo decoupling the front end from the byte sequencer
// depends on pfx_pkg
`default_nettype none

module pfx_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  pfx_pkg::cmd_t      push_cmd,
    input  wire logic          pop,
    output pfx_pkg::cmd_t      head_cmd,
    output logic               not_empty,
    output logic               not_full
);

    pfx_pkg::cmd_t                entry_reg [pfx_pkg::QUEUE_DEPTH];
    logic [pfx_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [pfx_pkg::QCNT_W-1:0]   count_reg, count_next;

    assign head_cmd  = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != pfx_pkg::QCNT_W'(pfx_pkg::QUEUE_DEPTH));

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + pfx_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - pfx_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + pfx_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + pfx_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: src/pfx_back.sv
// back end: walks each command through its frame bytes into the output register
// depends on pfx_pkg
`default_nettype none

module pfx_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  pfx_pkg::cmd_t                   head_cmd,
    input  wire logic                       head_valid,
    output logic                            pop,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [pfx_pkg::BYTE_W-1:0]      m_out_byte,
    output logic                            m_run_last,
    output logic                            m_frame_end
);

    pfx_pkg::cmd_t          cmd_reg;
    logic                   cmd_valid_reg;
    pfx_pkg::step_t         step_reg, step_next, first_step;
    logic                   out_valid_reg;
    logic [pfx_pkg::BYTE_W-1:0] out_byte_reg;
    logic                   out_last_reg, out_end_reg;
    logic                   out_free, advance, is_last;
    logic [pfx_pkg::BYTE_W-1:0] cur_byte;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = cmd_valid_reg && out_free;
    assign pop      = head_valid && (!cmd_valid_reg || (advance && is_last));

    // entry point of a fresh command
    always_comb begin
        if (head_cmd.has_header) begin
            first_step = pfx_pkg::ST_HDR;
        end else if (head_cmd.has_payload) begin
            first_step = pfx_pkg::ST_PAYLOAD;
        end else begin
            first_step = pfx_pkg::ST_TRAILER;
        end
    end

    always_comb begin
        step_next = step_reg;
        is_last   = 1'b0;
        cur_byte  = '0;
        unique case (step_reg)
            pfx_pkg::ST_HDR: begin
                cur_byte  = pfx_pkg::FRAME_HEADER;
                step_next = pfx_pkg::ST_LEN_LO;
            end
            pfx_pkg::ST_LEN_LO: begin
                cur_byte  = cmd_reg.length[7:0];
                step_next = pfx_pkg::ST_LEN_HI;
            end
            pfx_pkg::ST_LEN_HI: begin
                cur_byte  = cmd_reg.length[15:8];
                step_next = cmd_reg.has_payload ? pfx_pkg::ST_PAYLOAD : pfx_pkg::ST_TRAILER;
            end
            pfx_pkg::ST_PAYLOAD: begin
                cur_byte  = cmd_reg.payload;
                step_next = pfx_pkg::ST_TRAILER;
                is_last   = !cmd_reg.has_closing;
            end
            pfx_pkg::ST_TRAILER: begin
                cur_byte  = pfx_pkg::FRAME_TRAILER;
                step_next = pfx_pkg::ST_CHECK;
            end
            pfx_pkg::ST_CHECK: begin
                cur_byte = cmd_reg.checksum;
                is_last  = 1'b1;
            end
            default: begin
                step_next = pfx_pkg::ST_HDR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
            step_reg      <= pfx_pkg::ST_HDR;
        end else if (pop) begin
            cmd_valid_reg <= 1'b1;
            step_reg      <= first_step;
        end else if (advance) begin
            if (is_last) begin
                cmd_valid_reg <= 1'b0;
            end else begin
                step_reg <= step_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cmd_reg <= head_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= cmd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_byte_reg <= cur_byte;
            out_last_reg <= is_last;
            out_end_reg  <= (step_reg == pfx_pkg::ST_CHECK);
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_out_byte  = out_byte_reg;
    assign m_run_last  = out_last_reg;
    assign m_frame_end = out_end_reg;

endmodule

`default_nettype wire

// File: tb/pfx_frame_checker.sv
// frame checker for packet_framer_xor_checksum_unit: watches both channels,
// predicts the frame bytes of every input beat and compares them in order
// depends on pfx_pkg
`default_nettype none

module pfx_frame_checker #(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_payload_byte,
    input  wire logic [15:0] s_packet_length,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [7:0]  m_out_byte,
    input  wire logic        m_run_last,
    input  wire logic        m_frame_end,
    output int               errors,
    output int               pending
);

    localparam logic [15:0] LEN_MASK = 16'((32'd1 << LENGTH_BITS) - 1);

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       frame_end;
    } frame_byte_t;

    frame_byte_t expected_bytes[$];
    frame_byte_t want;

    // framer state as the block should hold it
    logic        in_pkt    = 1'b0;
    logic [15:0] remain    = '0;
    logic [7:0]  xsum      = '0;
    int          bad_count = 0;

    task automatic push_byte(input logic [7:0] b, input logic fe);
        expected_bytes.push_back(frame_byte_t'{b, 1'b0, fe});
    endtask

    task automatic close_frame();
        push_byte(pfx_pkg::FRAME_TRAILER, 1'b0);
        push_byte(xsum, 1'b1);
        in_pkt = 1'b0;
        remain = '0;
    endtask

    // all frame bytes caused by one accepted input beat
    task automatic frame_beat(input logic [7:0] pb, input logic [15:0] raw_len);
        logic [15:0] len;
        frame_byte_t tail;
        if (!in_pkt) begin
            len  = raw_len & LEN_MASK;
            xsum = 8'h00;
            push_byte(pfx_pkg::FRAME_HEADER, 1'b0);
            push_byte(len[7:0], 1'b0);
            push_byte(len[15:8], 1'b0);
            if (len == 16'd0) begin
                close_frame();
            end else begin
                xsum = pb;
                push_byte(pb, 1'b0);
                remain = (len - 16'd1) & LEN_MASK;
                if (remain == 16'd0) close_frame();
                else in_pkt = 1'b1;
            end
        end else begin
            xsum = xsum ^ pb;
            push_byte(pb, 1'b0);
            remain = (remain - 16'd1) & LEN_MASK;
            if (remain == 16'd0) close_frame();
        end
        tail = expected_bytes.pop_back();
        tail.run_last = 1'b1;
        expected_bytes.push_back(tail);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("unexpected frame byte: byte=%02h run_last=%0b frame_end=%0b",
                                 m_out_byte, m_run_last, m_frame_end);
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_out_byte !== want.data || m_run_last !== want.run_last ||
                        m_frame_end !== want.frame_end) begin
                        bad_count++;
                        if (bad_count <= 10)
                            $display({"frame byte differs: want byte=%02h run_last=%0b ",
                                      "frame_end=%0b, got byte=%02h run_last=%0b frame_end=%0b"},
                                     want.data, want.run_last, want.frame_end,
                                     m_out_byte, m_run_last, m_frame_end);
                    end
                end
            end
            if (s_valid && s_ready)
                frame_beat(s_payload_byte, s_packet_length);
        end
        pending <= expected_bytes.size();
        errors  <= bad_count;
    end

endmodule

`default_nettype wire

// File: tb/tb_packet_framer_xor_checksum_unit.sv
// testbench top for packet_framer_xor_checksum_unit: drives packets of
// directed and random lengths with random idling on both channels
// depends on pfx_pkg, the framer rtl and pfx_frame_checker
`default_nettype none

module tb_packet_framer_xor_checksum_unit;

    localparam int LENGTH_BITS = 16;
    // a correct run ends well before this limit
    localparam int CYCLE_LIMIT = 1_000_000;
    // idle time after the last expected byte, to watch for stray bytes
    localparam int DRAIN_CYCLES = 16;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_payload_byte;
    logic [15:0] s_packet_length;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic        m_run_last;
    logic        m_frame_end;

    int errors;
    int pending;
    int cycle_count = 0;
    int beats_sent  = 0;

    // 10 unit clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    packet_framer_xor_checksum_unit #(
        .LENGTH_BITS(LENGTH_BITS)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload_byte (s_payload_byte),
        .s_packet_length(s_packet_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_run_last     (m_run_last),
        .m_frame_end    (m_frame_end)
    );

    pfx_frame_checker #(
        .LENGTH_BITS(LENGTH_BITS)
    ) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload_byte (s_payload_byte),
        .s_packet_length(s_packet_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_run_last     (m_run_last),
        .m_frame_end    (m_frame_end),
        .errors         (errors),
        .pending        (pending)
    );

    // idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // one input beat: optional gap, then hold valid until the handshake
    task automatic send_beat(input logic [7:0] pb, input logic [15:0] len);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_payload_byte  = pb;
        s_packet_length = len;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        beats_sent++;
    endtask

    // whole packet with random bytes; later beats carry junk length fields
    task automatic send_packet(input logic [15:0] len);
        int i;
        send_beat(8'($urandom_range(0, 255)), len);
        for (i = 1; i < int'(len); i++)
            send_beat(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    endtask

    // frame byte receiver: stall runs alternate with stretches of ready
    initial begin
        int n;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            n = pick_gap();
            if (n > 0) begin
                m_ready = 1'b0;
                repeat (n - 1) @(negedge aclk);
                @(negedge aclk);
            end
            m_ready = 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge aclk);
        end
    end

    // hard stop in case the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("packet_framer_xor_checksum_unit: mismatch");
            $finish;
        end
    end

    initial begin
        int r;
        int len;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_payload_byte  = 8'h00;
        s_packet_length = 16'h0000;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // zero-length packet, its byte must be ignored
        send_beat(8'hFF, 16'd0);
        send_beat(8'h00, 16'd0);
        // single-byte packets give all six bytes from one beat
        send_beat(8'h00, 16'd1);
        send_beat(8'hFF, 16'd1);
        // length field mid-packet is ignored, including zero and all ones
        send_beat(8'hAA, 16'd2);
        send_beat(8'h55, 16'hFFFF);
        send_beat(8'h01, 16'd3);
        send_beat(8'h80, 16'd0);
        send_beat(8'h7E, 16'd1);
        send_beat(8'hE7, 16'd4);
        send_beat(8'hFF, 16'h8000);
        send_beat(8'hFF, 16'h0001);
        send_beat(8'h0F, 16'h7FFF);
        // zero-length right after a packet closes
        send_beat(8'h3C, 16'd0);

        // random packets, mostly short
        while (beats_sent < 190) begin
            r = $urandom_range(0, 99);
            if (r < 10) len = 0;
            else if (r < 30) len = 1;
            else if (r < 85) len = $urandom_range(2, 8);
            else len = $urandom_range(9, 40);
            send_packet(16'(len));
        end

        send_packet(16'd5);
        s_valid = 1'b0;

        // let every frame byte come out, then watch for strays
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (errors == 0 && pending == 0) begin
            $display("packet_framer_xor_checksum_unit: match");
        end else begin
            $display("packet_framer_xor_checksum_unit: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
